>>> hdl/program_stream_system_header_sync_macros.svh
// Assertion macros for the program stream system header sync block.
// Depends on nothing; included by the checker file.
`ifndef PROGRAM_STREAM_SYSTEM_HEADER_SYNC_MACROS_SVH
`define PROGRAM_STREAM_SYSTEM_HEADER_SYNC_MACROS_SVH

// same-cycle implication
`define PSSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pssh assertion failed");

// next-cycle implication
`define PSSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pssh assertion failed");

`endif

>>> hdl/pssh_pkg.sv
// Types and constants for the program stream system header sync block.
// Depends on nothing; used by every design module of the block and by the testbench.
package pssh_pkg;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_STUFF  = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [31:0] PACK_CODE   = 32'h0000_01BA;
	localparam logic [31:0] SYSTEM_CODE = 32'h0000_01BB;
	localparam logic [7:0]  STUFF_MASK  = 8'h07;
	localparam logic [3:0]  HEADER_SKIP = 4'd9;
	localparam logic [2:0]  WINDOW_FULL = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} item_t;

	typedef struct packed {
		logic pack_seen;
		logic found;
		logic done_res;
	} res_t;

endpackage

>>> hdl/pssh_in_stage.sv
// Input register of the system header sync block.
// Depends on pssh_pkg.
module pssh_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          data_valid,
	output logic          data_stall,
	input  logic [7:0]    data_byte,
	input  logic          stream_start,
	input  logic          next_ready,
	output logic          valid_s1,
	output pssh_pkg::item_t item_s1
);

	logic take;

	assign data_stall = valid_s1 && !next_ready;
	assign take       = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte    <= data_byte;
			item_s1.stream_start <= stream_start;
		end
	end

endmodule

>>> hdl/pssh_core.sv
// Per-byte search state and next-state logic of the system header sync block.
// Depends on pssh_pkg.
module pssh_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  pssh_pkg::item_t item_s1,
	output pssh_pkg::res_t  res
);

	logic [1:0]  phase_q,  phase_d,  phase_c;
	logic [31:0] window_q, window_d, window_c;
	logic [2:0]  fill_q,   fill_d,   fill_c;
	logic        expect_q, expect_d, expect_c;
	logic [3:0]  skip_q,   skip_d,   skip_c;
	logic [2:0]  stuff_len;
	logic        pack, hit;

	assign stuff_len = 3'(item_s1.data_byte & pssh_pkg::STUFF_MASK);

	always_comb begin
		phase_c  = item_s1.stream_start ? pssh_pkg::PH_SEARCH : phase_q;
		window_c = item_s1.stream_start ? 32'd0 : window_q;
		fill_c   = item_s1.stream_start ? 3'd0  : fill_q;
		expect_c = item_s1.stream_start ? 1'b0  : expect_q;
		skip_c   = item_s1.stream_start ? 4'd0  : skip_q;

		phase_d  = phase_c;
		window_d = window_c;
		fill_d   = fill_c;
		expect_d = expect_c;
		skip_d   = skip_c;
		pack     = 1'b0;
		hit      = 1'b0;

		unique case (phase_c)
			pssh_pkg::PH_SEARCH: begin
				window_d = {window_c[23:0], item_s1.data_byte};
				if (fill_c < pssh_pkg::WINDOW_FULL)
					fill_d = fill_c + 3'd1;
				if (fill_d >= pssh_pkg::WINDOW_FULL) begin
					expect_d = 1'b0;
					if (expect_c && window_d == pssh_pkg::SYSTEM_CODE) begin
						hit     = 1'b1;
						phase_d = pssh_pkg::PH_DONE;
					end else if (window_d == pssh_pkg::PACK_CODE) begin
						pack    = 1'b1;
						phase_d = pssh_pkg::PH_HEADER;
						skip_d  = 4'd0;
						fill_d  = 3'd0;
					end
				end
			end
			pssh_pkg::PH_HEADER: begin
				if (skip_c < pssh_pkg::HEADER_SKIP) begin
					skip_d = skip_c + 4'd1;
				end else if (stuff_len == 3'd0) begin
					skip_d   = 4'd0;
					phase_d  = pssh_pkg::PH_SEARCH;
					expect_d = 1'b1;
					fill_d   = 3'd0;
				end else begin
					skip_d  = {1'b0, stuff_len};
					phase_d = pssh_pkg::PH_STUFF;
				end
			end
			pssh_pkg::PH_STUFF: begin
				if (skip_c > 4'd1) begin
					skip_d = skip_c - 4'd1;
				end else begin
					skip_d   = 4'd0;
					phase_d  = pssh_pkg::PH_SEARCH;
					expect_d = 1'b1;
					fill_d   = 3'd0;
				end
			end
			default: begin
				phase_d = pssh_pkg::PH_DONE;
			end
		endcase

		res.pack_seen = pack;
		res.found     = hit;
		res.done_res  = (phase_d == pssh_pkg::PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pssh_pkg::PH_SEARCH;
			window_q <= 32'd0;
			fill_q   <= 3'd0;
			expect_q <= 1'b0;
			skip_q   <= 4'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			expect_q <= expect_d;
			skip_q   <= skip_d;
		end
	end

endmodule

>>> hdl/pssh_out_stage.sv
// Result register of the system header sync block.
// Depends on pssh_pkg.
module pssh_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  pssh_pkg::res_t res,
	output logic           ready,
	output logic           result_valid,
	input  logic           result_stall,
	output logic           pack_seen,
	output logic           found,
	output logic           done_res
);

	logic           valid_s2;
	pssh_pkg::res_t res_s2;

	assign ready = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign pack_seen    = res_s2.pack_seen;
	assign found        = res_s2.found;
	assign done_res     = res_s2.done_res;

endmodule

>>> hdl/program_stream_system_header_sync.sv
// Program stream system header sync: finds 000001BB right after a pack header.
// Path: the accepted byte is held in the input register and its flags are then
// registered in the result register, from which the result leaves.
// Throughput: one item per cycle while result_stall is low; the per-byte compare and count sits between
// the input register and the result register, with the search state updated in place.
// Reset: arst_n clears the search state and both stage valids at once.
module program_stream_system_header_sync (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       stream_start,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       pack_seen,
	output logic       found,
	output logic       done_res
);

	logic            valid_s1;
	logic            next_ready;
	pssh_pkg::item_t item_s1;
	pssh_pkg::res_t  res;

	pssh_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.next_ready   (next_ready),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	pssh_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (valid_s1 && next_ready),
		.item_s1 (item_s1),
		.res     (res)
	);

	pssh_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.res          (res),
		.ready        (next_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pack_seen    (pack_seen),
		.found        (found),
		.done_res     (done_res)
	);

endmodule

>>> hdl/pssh_checker.sv
// Port-level checker for the system header sync block, bound to the top level.
// Depends on program_stream_system_header_sync_macros.svh.
`include "program_stream_system_header_sync_macros.svh"

module pssh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic       pack_seen,
	input logic       found,
	input logic       done_res
);

	`PSSH_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable({pack_seen, found, done_res}))
	`PSSH_ASSERT_NOW(a_found_done, clk, arst_n, result_valid && found, done_res)
	`PSSH_ASSERT_NOW(a_one_code, clk, arst_n, result_valid, !(pack_seen && found))

endmodule

bind program_stream_system_header_sync pssh_checker u_pssh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.pack_seen    (pack_seen),
	.found        (found),
	.done_res     (done_res)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for program_stream_system_header_sync: directed table, then random pack sequences.
// Depends on pssh_pkg and the block; predicts flags per byte and checks every result item.
module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 450;

	typedef struct packed {
		pssh_pkg::item_t it;
		logic            typed;
		pssh_pkg::res_t  want;
	} stim_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_stall;
	logic [7:0] data_byte = 8'h00;
	logic       stream_start = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       pack_seen;
	logic       found;
	logic       done_res;

	program_stream_system_header_sync u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pack_seen    (pack_seen),
		.found        (found),
		.done_res     (done_res)
	);

	// columns: data_byte, stream_start, typed, {pack_seen, found, done_res}
	stim_t dir_rows [0:21] = '{
		{8'h00, 1'b0, 1'b1, 3'b000},
		{8'hFF, 1'b1, 1'b1, 3'b000},
		{8'h00, 1'b0, 1'b1, 3'b000},
		{8'h00, 1'b0, 1'b1, 3'b000},
		{8'h01, 1'b0, 1'b1, 3'b000},
		{8'hBA, 1'b0, 1'b1, 3'b100},
		{8'hFF, 1'b0, 1'b0, 3'b000},
		{8'h00, 1'b0, 1'b0, 3'b000},
		{8'hFF, 1'b0, 1'b0, 3'b000},
		{8'h00, 1'b0, 1'b0, 3'b000},
		{8'h55, 1'b0, 1'b0, 3'b000},
		{8'hAA, 1'b0, 1'b0, 3'b000},
		{8'h80, 1'b0, 1'b0, 3'b000},
		{8'h7F, 1'b0, 1'b0, 3'b000},
		{8'h01, 1'b0, 1'b0, 3'b000},
		{8'hF8, 1'b0, 1'b0, 3'b000},
		{8'h00, 1'b0, 1'b0, 3'b000},
		{8'h00, 1'b0, 1'b0, 3'b000},
		{8'h01, 1'b0, 1'b0, 3'b000},
		{8'hBB, 1'b0, 1'b1, 3'b011},
		{8'hFF, 1'b0, 1'b1, 3'b001},
		{8'h00, 1'b1, 1'b1, 3'b000}
	};

	stim_t           byte_queue [$];
	pssh_pkg::res_t  expected_flags [$];
	stim_t           in_flight;

	logic [1:0]  sync_phase = pssh_pkg::PH_SEARCH;
	logic [31:0] search_window = '0;
	logic [2:0]  window_count = '0;
	logic        check_pending = 1'b0;
	logic [3:0]  skip_left = '0;

	int  errors = 0;
	int  cycle_count = 0;
	int  queued_count = 0;
	int  accepted_count = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  start_pend = 1'b0;
	bit  gen_found = 1'b0;

	always #6 clk = ~clk;

	function automatic pssh_pkg::res_t sync_step(pssh_pkg::item_t it);
		pssh_pkg::res_t r;
		logic [7:0]     n;
		r = '0;
		if (it.stream_start) begin
			sync_phase = pssh_pkg::PH_SEARCH;
			search_window = '0;
			window_count = '0;
			check_pending = 1'b0;
			skip_left = '0;
		end
		case (sync_phase)
			pssh_pkg::PH_SEARCH: begin
				search_window = {search_window[23:0], it.data_byte};
				if (window_count < pssh_pkg::WINDOW_FULL)
					window_count = window_count + 3'd1;
				if (window_count >= pssh_pkg::WINDOW_FULL) begin
					if (check_pending && search_window == pssh_pkg::SYSTEM_CODE) begin
						r.found = 1'b1;
						sync_phase = pssh_pkg::PH_DONE;
						check_pending = 1'b0;
					end else begin
						check_pending = 1'b0;
						if (search_window == pssh_pkg::PACK_CODE) begin
							r.pack_seen = 1'b1;
							sync_phase = pssh_pkg::PH_HEADER;
							skip_left = '0;
							window_count = '0;
						end
					end
				end
			end
			pssh_pkg::PH_HEADER: begin
				if (skip_left < pssh_pkg::HEADER_SKIP) begin
					skip_left = skip_left + 4'd1;
				end else begin
					n = it.data_byte & pssh_pkg::STUFF_MASK;
					if (n == 8'd0) begin
						skip_left = '0;
						sync_phase = pssh_pkg::PH_SEARCH;
						check_pending = 1'b1;
						window_count = '0;
					end else begin
						skip_left = n[3:0];
						sync_phase = pssh_pkg::PH_STUFF;
					end
				end
			end
			pssh_pkg::PH_STUFF: begin
				if (skip_left > 4'd1) begin
					skip_left = skip_left - 4'd1;
				end else begin
					skip_left = '0;
					sync_phase = pssh_pkg::PH_SEARCH;
					check_pending = 1'b1;
					window_count = '0;
				end
			end
			default: sync_phase = pssh_pkg::PH_DONE;
		endcase
		r.done_res = (sync_phase == pssh_pkg::PH_DONE);
		return r;
	endfunction

	task automatic flag_error(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
		errors++;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0, 1: return 8'h00;
			2: return 8'h01;
			3: return 8'hBA;
			4: return 8'hBB;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_byte(logic [7:0] b);
		logic ss;
		ss = start_pend || ($urandom_range(0, 99) == 0);
		start_pend = 1'b0;
		byte_queue.push_back({b, ss, 1'b0, 3'b000});
		queued_count++;
	endtask

	task automatic push_code(logic [7:0] last);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(last);
	endtask

	task automatic gen_sequence();
		int         n;
		int         tail;
		bit         chain;
		logic [7:0] hdr10;
		start_pend = gen_found ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
		if (start_pend)
			gen_found = 1'b0;
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6)) push_byte(pick_byte());
			return;
		end
		repeat ($urandom_range(0, 3)) push_byte(pick_byte());
		push_code(8'hBA);
		chain = 1'b1;
		while (chain) begin
			chain = 1'b0;
			repeat (9) push_byte(8'($urandom));
			n = $urandom_range(0, 7);
			hdr10 = 8'($urandom);
			hdr10[2:0] = n[2:0];
			push_byte(hdr10);
			repeat (n) push_byte(pick_byte());
			tail = $urandom_range(0, 99);
			if (tail < 50) begin
				push_code(8'hBB);
				gen_found = 1'b1;
				repeat ($urandom_range(0, 2)) push_byte(pick_byte());
			end else if (tail < 65) begin
				push_code(8'hBA);
				chain = 1'b1;
			end else if (tail < 85) begin
				repeat (4) push_byte(pick_byte());
			end else begin
				push_code(pick_byte());
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && !data_stall) begin
				expected_flags.push_back(in_flight.typed ? in_flight.want : sync_step(in_flight.it));
				if (in_flight.typed)
					void'(sync_step(in_flight.it));
				accepted_count++;
			end
			if (!(data_valid && data_stall)) begin
				if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_flight = byte_queue.pop_front();
					data_valid <= 1'b1;
					data_byte <= in_flight.it.data_byte;
					stream_start <= in_flight.it.stream_start;
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		pssh_pkg::res_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_flags.size() == 0) begin
					flag_error("unexpected result item", 1, 0);
				end else begin
					want = expected_flags.pop_front();
					if (pack_seen !== want.pack_seen)
						flag_error("pack_seen", pack_seen, want.pack_seen);
					if (found !== want.found)
						flag_error("found", found, want.found);
					if (done_res !== want.done_res)
						flag_error("done_res", done_res, want.done_res);
				end
			end
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("program_stream_system_header_sync verification failed");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			@(negedge clk);
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 56 : 0;
			recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 36 : 0;
			if (ph == 0) begin
				foreach (dir_rows[i]) begin
					byte_queue.push_back(dir_rows[i]);
					queued_count++;
				end
			end
			target = queued_count + RANDOM_PER_PHASE;
			while (queued_count < target)
				gen_sequence();
			// wait until every result item of this phase is back before the next phase starts
			while (accepted_count != queued_count || expected_flags.size() != 0)
				@(negedge clk);
		end
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("program_stream_system_header_sync verification clean");
		else
			$display("program_stream_system_header_sync verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/pssh_pkg.sv
hdl/pssh_in_stage.sv
hdl/pssh_core.sv
hdl/pssh_out_stage.sv
hdl/program_stream_system_header_sync.sv
hdl/pssh_checker.sv
verif/tb.sv
